>>> src/sdcb_pkg.sv
// sdcb_pkg: shared constants, result kind codes, controller state and
// the command/status structs between the controller and the datapath.
`timescale 1ns / 1ps
package sdcb_pkg;

  localparam int MAX_ENTRIES       = 8;
  localparam int SECTORS_PER_ENTRY = 16;
  localparam int SECTOR_BYTES      = 512;
  localparam int MAX_SECTORS       = MAX_ENTRIES * SECTORS_PER_ENTRY;
  localparam int ENTRY_STEP        = SECTORS_PER_ENTRY * SECTOR_BYTES;

  localparam int SLOT_CNT_W = 6;
  localparam int SLOT_W     = 5;
  localparam int NUM_SLOTS  = 32;
  localparam int ENT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int REM_W      = $clog2(MAX_SECTORS + 1);
  localparam int BYTES_W    = 13;

  localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RESET = SLOT_CNT_W'(32);

  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_ENTRY     = 2'd1;
  localparam logic [1:0] KIND_NOSLOT    = 2'd2;
  localparam logic [1:0] KIND_BADCOUNT  = 2'd3;

  localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ENTRY
  } sdcb_state_t;

  typedef struct packed {
    logic load;
    logic head;
    logic entry;
  } sdcb_cmd_t;

  typedef struct packed {
    logic reject;
    logic last_entry;
  } sdcb_sts_t;

endpackage

>>> src/sdcb_ctrl.sv
// sdcb_ctrl: controller state machine sequencing header and scatter entries.
// Depends on sdcb_pkg for the state type and command/status structs.
`timescale 1ns / 1ps
module sdcb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdcb_pkg::sdcb_sts_t sts,
  output sdcb_pkg::sdcb_cmd_t cmd
);
  import sdcb_pkg::*;

  sdcb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        state_nxt = sts.reject ? ST_IDLE : ST_ENTRY;
      end
      ST_ENTRY: begin
        if (sts.last_entry) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_HEAD:  cmd.head = 1'b1;
      ST_ENTRY: cmd.entry = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

>>> src/sdcb_dp.sv
// sdcb_dp: request registers, slot search, count check, entry address and
// length generation, and the result field mux. Depends on sdcb_pkg.
`timescale 1ns / 1ps
module sdcb_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sdcb_pkg::SLOT_CNT_W-1:0]    cfg_wdata,
  input  sdcb_pkg::sdcb_cmd_t                cmd,
  output sdcb_pkg::sdcb_sts_t                sts,
  input  logic                               in_mode,
  input  logic [4:0]                         in_port_number,
  input  logic [47:0]                        in_lba,
  input  logic [15:0]                        in_sector_count,
  input  logic [31:0]                        in_buffer_address,
  input  logic [31:0]                        in_busy_mask,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [4:0]                         out_port_out,
  output logic [4:0]                         out_slot,
  output logic                               out_write_flag,
  output logic [3:0]                         out_entry_count,
  output logic [7:0]                         out_command_code,
  output logic [47:0]                        out_lba_out,
  output logic [7:0]                         out_count_out,
  output logic [31:0]                        out_entry_address,
  output logic [12:0]                        out_entry_bytes_minus_one,
  output logic                               out_last
);
  import sdcb_pkg::*;

  logic [SLOT_CNT_W-1:0] slot_count_r;
  logic                  mode_r;
  logic [4:0]            port_r;
  logic [47:0]           lba_r;
  logic [7:0]            count_r;
  logic [31:0]           addr_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  found_r;
  logic                  bad_r;
  logic [ENT_W-1:0]      nent_r;
  logic [ENT_W-1:0]      idx_r;
  logic [REM_W-1:0]      rem_r;

  logic [SLOT_CNT_W-1:0] nslots;
  logic                  found;
  logic [SLOT_W-1:0]     slot_sel;
  logic                  bad_count;
  logic [15:0]           nent_full;
  logic [ENT_W-1:0]      idx_inc;
  logic [REM_W+9:0]      fin_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RESET;
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    nslots   = (slot_count_r > SLOT_CNT_W'(NUM_SLOTS)) ? SLOT_CNT_W'(NUM_SLOTS) : slot_count_r;
    found    = 1'b0;
    slot_sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_busy_mask[i] && (SLOT_CNT_W'(i) < nslots)) begin
        found    = 1'b1;
        slot_sel = SLOT_W'(i);
      end
    end
  end

  assign bad_count = (in_sector_count == 16'd0) ||
                     (in_sector_count > 16'(MAX_SECTORS));
  assign nent_full = (in_sector_count - 16'd1) / 16'(SECTORS_PER_ENTRY) + 16'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      port_r  <= in_port_number;
      lba_r   <= in_lba;
      count_r <= in_sector_count[7:0];
      addr_r  <= in_buffer_address;
      slot_r  <= slot_sel;
      found_r <= found;
      bad_r   <= bad_count;
      nent_r  <= nent_full[ENT_W-1:0];
      idx_r   <= '0;
      rem_r   <= in_sector_count[REM_W-1:0];
    end else if (cmd.entry) begin
      addr_r <= addr_r + 32'(ENTRY_STEP);
      idx_r  <= idx_inc;
      rem_r  <= rem_r - REM_W'(SECTORS_PER_ENTRY);
    end
  end

  assign idx_inc        = idx_r + ENT_W'(1);
  assign sts.last_entry = (idx_inc == nent_r);
  assign sts.reject     = !found_r || bad_r;
  assign fin_bytes      = (REM_W+10)'(rem_r) * (REM_W+10)'(SECTOR_BYTES) - (REM_W+10)'(1);

  always_comb begin
    out_valid                 = cmd.head || cmd.entry;
    out_kind                  = KIND_HEADER;
    out_port_out              = port_r;
    out_slot                  = '0;
    out_write_flag            = 1'b0;
    out_entry_count           = '0;
    out_command_code          = '0;
    out_lba_out               = '0;
    out_count_out             = '0;
    out_entry_address         = '0;
    out_entry_bytes_minus_one = '0;
    out_last                  = 1'b0;
    if (cmd.entry) begin
      out_kind                  = KIND_ENTRY;
      out_slot                  = slot_r;
      out_entry_address         = addr_r;
      out_entry_bytes_minus_one = sts.last_entry ? fin_bytes[BYTES_W-1:0]
                                                 : BYTES_W'(ENTRY_STEP - 1);
      out_last                  = sts.last_entry;
    end else if (!found_r) begin
      out_kind = KIND_NOSLOT;
      out_last = 1'b1;
    end else if (bad_r) begin
      out_kind = KIND_BADCOUNT;
      out_last = 1'b1;
    end else begin
      out_slot         = slot_r;
      out_write_flag   = mode_r;
      out_entry_count  = 4'(nent_r);
      out_command_code = mode_r ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
      out_lba_out      = lba_r;
      out_count_out    = count_r;
    end
  end

endmodule

>>> src/sata_dma_command_builder_core.sv
// SATA DMA command builder top level: controller plus datapath.
// Usage notes below. Depends on sdcb_pkg, sdcb_ctrl and sdcb_dp.
//
// Input channel: a request (in_* ports) is taken at a clock edge with start
// high and busy low. The request is held internally, so the in_* ports are
// free after that edge.
// Result channel: each result shows on the out_* ports for one cycle with
// out_valid high. The receiver cannot stall; every strobed result counts.
// A good request gives a header in the cycle after acceptance, then one
// scatter entry per cycle, out_last on the final entry. A rejected request
// gives one error result (out_last high) in the cycle after acceptance.
// Occupancy: busy stays high through the header and the N entries, N the
// entry count (1..8), or through the error result; no new request is taken then.
// The rate is set by the entry sequencer emitting one entry per cycle.
// Configuration: cfg_we/cfg_wdata write slot_count; write only when idle.
// Reset (rst_n low, synchronous): controller idles, slot_count returns to 32.
`timescale 1ns / 1ps
module sata_dma_command_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [4:0]  in_port_number,
  input  logic [47:0] in_lba,
  input  logic [15:0] in_sector_count,
  input  logic [31:0] in_buffer_address,
  input  logic [31:0] in_busy_mask,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [4:0]  out_port_out,
  output logic [4:0]  out_slot,
  output logic        out_write_flag,
  output logic [3:0]  out_entry_count,
  output logic [7:0]  out_command_code,
  output logic [47:0] out_lba_out,
  output logic [7:0]  out_count_out,
  output logic [31:0] out_entry_address,
  output logic [12:0] out_entry_bytes_minus_one,
  output logic        out_last
);
  import sdcb_pkg::*;

  sdcb_cmd_t cmd;
  sdcb_sts_t sts;

  sdcb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sdcb_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_wdata                 (cfg_wdata),
    .cmd                       (cmd),
    .sts                       (sts),
    .in_mode                   (in_mode),
    .in_port_number            (in_port_number),
    .in_lba                    (in_lba),
    .in_sector_count           (in_sector_count),
    .in_buffer_address         (in_buffer_address),
    .in_busy_mask              (in_busy_mask),
    .out_valid                 (out_valid),
    .out_kind                  (out_kind),
    .out_port_out              (out_port_out),
    .out_slot                  (out_slot),
    .out_write_flag            (out_write_flag),
    .out_entry_count           (out_entry_count),
    .out_command_code          (out_command_code),
    .out_lba_out               (out_lba_out),
    .out_count_out             (out_count_out),
    .out_entry_address         (out_entry_address),
    .out_entry_bytes_minus_one (out_entry_bytes_minus_one),
    .out_last                  (out_last)
  );

`ifndef SYNTHESIS
  a_accept_gives_head: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid && out_kind != KIND_ENTRY))
    else $error("accepted transaction did not produce a header or error result");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result strobed after the final result of a transaction");

  a_entries_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ENTRY && !out_last) |=>
      (out_valid && out_kind == KIND_ENTRY))
    else $error("scatter entry run broken before its final entry");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid)
    else $error("result strobed while idle");
`endif

endmodule

>>> dv/tb_sata_dma_command_builder_core.sv
// Testbench for sata_dma_command_builder_core: drives disk requests and checks the
// header, scatter entry and error results against an in-bench command planner.
// Depends on sdcb_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb_sata_dma_command_builder_core;
  import sdcb_pkg::*;

  typedef struct {
    bit        mode;
    bit [4:0]  port;
    bit [47:0] lba;
    bit [15:0] count;
    bit [31:0] buf_addr;
    bit [31:0] busy_mask;
  } disk_req_t;

  typedef struct {
    bit [1:0]  kind;
    bit [4:0]  port;
    bit [4:0]  slot;
    bit        wr;
    bit [3:0]  ecount;
    bit [7:0]  cmd;
    bit [47:0] lba;
    bit [7:0]  cnt;
    bit [31:0] addr;
    bit [12:0] bytes_m1;
    bit        last;
  } cmd_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [4:0]  in_port_number = '0;
  logic [47:0] in_lba = '0;
  logic [15:0] in_sector_count = '0;
  logic [31:0] in_buffer_address = '0;
  logic [31:0] in_busy_mask = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [4:0]  out_port_out;
  logic [4:0]  out_slot;
  logic        out_write_flag;
  logic [3:0]  out_entry_count;
  logic [7:0]  out_command_code;
  logic [47:0] out_lba_out;
  logic [7:0]  out_count_out;
  logic [31:0] out_entry_address;
  logic [12:0] out_entry_bytes_minus_one;
  logic        out_last;

  disk_req_t   req_q[$];
  cmd_result_t planned_q[$];
  bit [5:0]    slot_cfg = SLOT_COUNT_RESET;
  int          idle_pct = 0;
  int          n_errors = 0;

  sata_dma_command_builder_core dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_wdata                 (cfg_wdata),
    .start                     (start),
    .busy                      (busy),
    .in_mode                   (in_mode),
    .in_port_number            (in_port_number),
    .in_lba                    (in_lba),
    .in_sector_count           (in_sector_count),
    .in_buffer_address         (in_buffer_address),
    .in_busy_mask              (in_busy_mask),
    .out_valid                 (out_valid),
    .out_kind                  (out_kind),
    .out_port_out              (out_port_out),
    .out_slot                  (out_slot),
    .out_write_flag            (out_write_flag),
    .out_entry_count           (out_entry_count),
    .out_command_code          (out_command_code),
    .out_lba_out               (out_lba_out),
    .out_count_out             (out_count_out),
    .out_entry_address         (out_entry_address),
    .out_entry_bytes_minus_one (out_entry_bytes_minus_one),
    .out_last                  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Plan the header and scatter entries (or the error) for one request.
  function automatic void build_prd_list(disk_req_t r);
    int          nslots;
    int          slot;
    int          nent;
    int          rem;
    bit [31:0]   addr;
    cmd_result_t e;
    nslots = (slot_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(slot_cfg);
    slot = -1;
    for (int i = nslots - 1; i >= 0; i--) begin
      if (!r.busy_mask[i]) slot = i;
    end
    e = '{default: '0};
    e.port = r.port;
    if (slot < 0 || r.count == 0 || r.count > MAX_SECTORS) begin
      e.kind = (slot < 0) ? KIND_NOSLOT : KIND_BADCOUNT;
      e.last = 1'b1;
      planned_q.push_back(e);
      return;
    end
    nent = (int'(r.count) - 1) / SECTORS_PER_ENTRY + 1;
    e.kind   = KIND_HEADER;
    e.slot   = 5'(slot);
    e.wr     = r.mode;
    e.ecount = 4'(nent);
    e.cmd    = r.mode ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
    e.lba    = r.lba;
    e.cnt    = r.count[7:0];
    planned_q.push_back(e);
    rem = int'(r.count);
    addr = r.buf_addr;
    for (int i = 0; i < nent; i++) begin
      e = '{default: '0};
      e.kind = KIND_ENTRY;
      e.port = r.port;
      e.slot = 5'(slot);
      e.addr = addr;
      e.last = (i == nent - 1);
      e.bytes_m1 = e.last ? 13'(rem * SECTOR_BYTES - 1) : 13'(ENTRY_STEP - 1);
      planned_q.push_back(e);
      addr += 32'(ENTRY_STEP);
      rem -= SECTORS_PER_ENTRY;
    end
  endfunction

  function automatic disk_req_t mk_req(bit mode, bit [4:0] port, bit [47:0] lba,
                                       bit [15:0] count, bit [31:0] buf_addr,
                                       bit [31:0] busy_mask);
    disk_req_t r;
    r.mode = mode;
    r.port = port;
    r.lba = lba;
    r.count = count;
    r.buf_addr = buf_addr;
    r.busy_mask = busy_mask;
    return r;
  endfunction

  function automatic disk_req_t rand_req();
    disk_req_t r;
    int        sel;
    int        k;
    bit [31:0] low_ones;
    r.mode = 1'($urandom_range(1));
    r.port = 5'($urandom);
    r.lba[47:32] = 16'($urandom);
    r.lba[31:0] = $urandom;
    sel = $urandom_range(99);
    if (sel < 8) r.count = '0;
    else if (sel < 16) r.count = 16'($urandom_range(65535, MAX_SECTORS + 1));
    else if (sel < 30) begin
      case ($urandom_range(5))
        0: r.count = 16'd1;
        1: r.count = 16'(SECTORS_PER_ENTRY);
        2: r.count = 16'(SECTORS_PER_ENTRY + 1);
        3: r.count = 16'(MAX_SECTORS - 1);
        4: r.count = 16'(MAX_SECTORS - SECTORS_PER_ENTRY);
        default: r.count = 16'(MAX_SECTORS);
      endcase
    end else r.count = 16'($urandom_range(MAX_SECTORS, 1));
    sel = $urandom_range(99);
    if (sel < 10) r.buf_addr = 32'hFFFF_0000 | ($urandom & 32'h0000_FFFF);
    else r.buf_addr = $urandom;
    sel = $urandom_range(99);
    if (sel < 10) r.busy_mask = '0;
    else if (sel < 20) r.busy_mask = '1;
    else if (sel < 60) begin
      k = $urandom_range(NUM_SLOTS);
      low_ones = 32'hFFFF_FFFF >> (NUM_SLOTS - k);
      r.busy_mask = low_ones | ($urandom << k);
    end else r.busy_mask = $urandom;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Driver: a transaction is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        build_prd_list(req_q[0]);
        void'(req_q.pop_front());
      end
      if (!start || !busy) begin
        if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_mode           <= req_q[0].mode;
          in_port_number    <= req_q[0].port;
          in_lba            <= req_q[0].lba;
          in_sector_count   <= req_q[0].count;
          in_buffer_address <= req_q[0].buf_addr;
          in_busy_mask      <= req_q[0].busy_mask;
          start             <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest planned one.
  always @(posedge clk) begin
    cmd_result_t e;
    if (rst_n && out_valid) begin
      if (planned_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result, expected none, actual kind %0d port %0d",
                 $time, out_kind, out_port_out);
      end else begin
        e = planned_q.pop_front();
        check_field("kind", 64'(e.kind), 64'(out_kind));
        check_field("port_out", 64'(e.port), 64'(out_port_out));
        check_field("slot", 64'(e.slot), 64'(out_slot));
        check_field("write_flag", 64'(e.wr), 64'(out_write_flag));
        check_field("entry_count", 64'(e.ecount), 64'(out_entry_count));
        check_field("command_code", 64'(e.cmd), 64'(out_command_code));
        check_field("lba_out", 64'(e.lba), 64'(out_lba_out));
        check_field("count_out", 64'(e.cnt), 64'(out_count_out));
        check_field("entry_address", 64'(e.addr), 64'(out_entry_address));
        check_field("entry_bytes_minus_one", 64'(e.bytes_m1),
                    64'(out_entry_bytes_minus_one));
        check_field("last", 64'(e.last), 64'(out_last));
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || planned_q.size() != 0 || start || busy);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_slot_count(bit [5:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    slot_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n, int pct, bit [5:0] slots);
    wait_idle();
    write_slot_count(slots);
    @(negedge clk);
    idle_pct = pct;
    repeat (n) req_q.push_back(rand_req());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 0;
    req_q.push_back(mk_req(1'b0, 5'd0, 48'h0, 16'd1, 32'h0, 32'h0));
    req_q.push_back(mk_req(1'b1, 5'd31, 48'hFFFF_FFFF_FFFF, 16'd128, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF));
    req_q.push_back(mk_req(1'b0, 5'd3, 48'h1234_5678_9ABC, 16'd16, 32'hFFFF_E000, 32'h1));
    req_q.push_back(mk_req(1'b1, 5'd4, 48'h0000_0000_0001, 16'd17, 32'hFFFF_E000, 32'h3));
    req_q.push_back(mk_req(1'b0, 5'd5, 48'h8000_0000_0000, 16'd0, 32'h1000, 32'h0));
    req_q.push_back(mk_req(1'b1, 5'd6, 48'h0, 16'd129, 32'h2000, 32'h0));
    req_q.push_back(mk_req(1'b0, 5'd7, 48'h0, 16'hFFFF, 32'h3000, 32'h0));
    req_q.push_back(mk_req(1'b0, 5'd8, 48'h0, 16'h8000, 32'h3000, 32'h0));
    req_q.push_back(mk_req(1'b1, 5'd9, 48'hAAAA_AAAA_AAAA, 16'd5, 32'h4000, 32'hFFFF_FFFF));
    req_q.push_back(mk_req(1'b0, 5'd10, 48'h5555_5555_5555, 16'd0, 32'h0, 32'hFFFF_FFFF));
    req_q.push_back(mk_req(1'b0, 5'd11, 48'h0000_FFFF_0000, 16'd127, 32'hAAAA_AAAA,
                           32'h0000_00FF));
    req_q.push_back(mk_req(1'b1, 5'd12, 48'hFFFF_0000_FFFF, 16'd112, 32'h5555_5555,
                           32'h5555_5555));
    req_q.push_back(mk_req(1'b1, 5'd16, 48'h8000_0000_0000, 16'd33, 32'h1234_5678,
                           32'h0000_FFFF));
    req_q.push_back(mk_req(1'b0, 5'd21, 48'h0, 16'd32, 32'hFFFF_C000, 32'hFFFF_FFFE));
    run_random(25, 61, 6'd1);
    run_random(8, 0, 6'd0);
    run_random(30, 23, 6'd63);
    run_random(25, 61, 6'd5);
    run_random(15, 0, 6'd17);
    run_random(15, 0, 6'd32);
    wait_idle();
    if (planned_q.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("** sata_dma_command_builder_core: PASSED **");
    end else begin
      $display("** sata_dma_command_builder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** sata_dma_command_builder_core: FAILED **");
    $finish;
  end

endmodule
